FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of clk, ignored while rstn is low.
`define PPLRJ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same on the standard clk_i / rst_ni pair.
`define PPLRJ_ASSERT(lbl, prop, msg) `PPLRJ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: src/pplrj_pkg.sv
// ----------------------------------------------------------------------------
// pplrj_pkg
// Widths, codes and fixed-point helpers of the residual/Jacobian unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pplrj_pkg;

  localparam int unsigned PW   = 24;  // points, 1/1024 m
  localparam int unsigned DW   = 18;  // directions, Q1.16
  localparam int unsigned CW   = 21;  // packed register entry
  localparam int unsigned CFGW = 3 * CW;
  localparam int unsigned NREG = 8;
  localparam int unsigned IDXW = $clog2(NREG);
  localparam int unsigned WPW  = 28;  // rotated point
  localparam int unsigned WDW  = 22;  // rotated direction
  localparam int unsigned VW   = 30;  // world-frame difference
  localparam int unsigned SW   = 56;  // unrounded sums
  localparam int unsigned MW   = 26;  // rotation times direction
  localparam int unsigned MVW  = 34;  // rotation times difference
  localparam int unsigned TW   = MW + 1;
  localparam int unsigned OW   = 32;
  localparam int unsigned RW   = 2;   // residual row

  localparam int unsigned NITEM_PLANE = 2;
  localparam int unsigned NITEM_EDGE  = 6;
  localparam int unsigned IXW = $clog2(NITEM_EDGE);
  localparam logic [IXW-1:0] LAST_PLANE = IXW'(NITEM_PLANE - 1);
  localparam logic [IXW-1:0] LAST_EDGE  = IXW'(NITEM_EDGE - 1);

  typedef enum logic {
    KIND_PLANE = 1'b0,
    KIND_EDGE  = 1'b1
  } kind_e;

  typedef enum logic [IDXW-1:0] {
    REG_ROT_I_ROW0 = 3'd0,
    REG_ROT_I_ROW1 = 3'd1,
    REG_ROT_I_ROW2 = 3'd2,
    REG_ROT_J_ROW0 = 3'd3,
    REG_ROT_J_ROW1 = 3'd4,
    REG_ROT_J_ROW2 = 3'd5,
    REG_TRANS_I    = 3'd6,
    REG_TRANS_J    = 3'd7
  } cfg_reg_e;

  localparam logic signed [SW-1:0] HALF16 = 56'sd32768;
  localparam logic signed [SW-1:0] HALF19 = 56'sd262144;
  localparam logic signed [SW-1:0] SMAX   = 56'sd2147483647;
  localparam logic signed [SW-1:0] SMIN   = -56'sd2147483648;

  // Round to nearest, ties toward plus infinity.
  function automatic logic signed [SW-1:0] rnd16(input logic signed [SW-1:0] x);
    return (x + HALF16) >>> 16;
  endfunction

  function automatic logic signed [SW-1:0] rnd19(input logic signed [SW-1:0] x);
    return (x + HALF19) >>> 19;
  endfunction

  function automatic logic signed [OW-1:0] sat32(input logic signed [SW-1:0] x);
    logic signed [OW-1:0] r;
    if (x > SMAX) begin
      r = SMAX[OW-1:0];
    end else if (x < SMIN) begin
      r = SMIN[OW-1:0];
    end else begin
      r = x[OW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/pplrj_in_if.sv
// ----------------------------------------------------------------------------
// pplrj_in_if
// Correspondence channel: valid/ready plus one constraint.
// ----------------------------------------------------------------------------
`default_nettype none

interface pplrj_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [pplrj_pkg::PW-1:0]     src_x;
  logic signed [pplrj_pkg::PW-1:0]     src_y;
  logic signed [pplrj_pkg::PW-1:0]     src_z;
  logic signed [pplrj_pkg::DW-1:0]     dir_x;
  logic signed [pplrj_pkg::DW-1:0]     dir_y;
  logic signed [pplrj_pkg::DW-1:0]     dir_z;
  logic signed [pplrj_pkg::PW-1:0]     dst_x;
  logic signed [pplrj_pkg::PW-1:0]     dst_y;
  logic signed [pplrj_pkg::PW-1:0]     dst_z;

  modport source (output valid, kind, src_x, src_y, src_z, dir_x, dir_y, dir_z,
                  dst_x, dst_y, dst_z, input ready);
  modport sink   (input valid, kind, src_x, src_y, src_z, dir_x, dir_y, dir_z,
                  dst_x, dst_y, dst_z, output ready);
endinterface

`default_nettype wire

FILE: src/pplrj_out_if.sv
// ----------------------------------------------------------------------------
// pplrj_out_if
// Result channel: valid/ready plus one Jacobian row against one pose.
// ----------------------------------------------------------------------------
`default_nettype none

interface pplrj_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pplrj_pkg::OW-1:0]     residual_value;
  logic [pplrj_pkg::RW-1:0]            residual_row;
  logic                                pose_sel;
  logic signed [pplrj_pkg::OW-1:0]     rot_x;
  logic signed [pplrj_pkg::OW-1:0]     rot_y;
  logic signed [pplrj_pkg::OW-1:0]     rot_z;
  logic signed [pplrj_pkg::OW-1:0]     trans_x;
  logic signed [pplrj_pkg::OW-1:0]     trans_y;
  logic signed [pplrj_pkg::OW-1:0]     trans_z;
  logic                                last;

  modport source (output valid, residual_value, residual_row, pose_sel, rot_x, rot_y,
                  rot_z, trans_x, trans_y, trans_z, last, input ready);
  modport sink   (input valid, residual_value, residual_row, pose_sel, rot_x, rot_y,
                  rot_z, trans_x, trans_y, trans_z, last, output ready);
endinterface

`default_nettype wire

FILE: src/point_plane_line_residual_jacobian.sv
// An accepted correspondence passes through stages A, B, C and D and then the result
// buffer before its first result item is valid. Throughput: one result item per cycle
// while res_o.ready is high; a plane constraint gives 2 items and an edge constraint 6,
// drained by the result buffer. A correspondence can enter the four-stage pipeline every
// cycle until the buffer backs it up; sustained, one constraint per buffer drain.
// Reset clears all pose registers to zero and empties the pipeline and buffer.
// ----------------------------------------------------------------------------
// point_plane_line_residual_jacobian
// Point-to-plane and point-to-line residuals with Jacobians against two poses.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module point_plane_line_residual_jacobian (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pplrj_pkg::IDXW-1:0]      cfg_idx_i,
  input  logic [pplrj_pkg::CFGW-1:0]      cfg_wdata_i,
  pplrj_in_if.sink                        pt_i,
  pplrj_out_if.source                     res_o
);

  localparam int CW  = pplrj_pkg::CW;
  localparam int PW  = pplrj_pkg::PW;
  localparam int DW  = pplrj_pkg::DW;
  localparam int WPW = pplrj_pkg::WPW;
  localparam int WDW = pplrj_pkg::WDW;
  localparam int VW  = pplrj_pkg::VW;
  localparam int SW  = pplrj_pkg::SW;
  localparam int MW  = pplrj_pkg::MW;
  localparam int MVW = pplrj_pkg::MVW;
  localparam int TW  = pplrj_pkg::TW;
  localparam int OW  = pplrj_pkg::OW;
  localparam int IXW = pplrj_pkg::IXW;

  // --------------------------------------------------------------------------
  // Pose registers
  // --------------------------------------------------------------------------
  logic [pplrj_pkg::CFGW-1:0] cfg_q [pplrj_pkg::NREG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pplrj_pkg::NREG; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  logic signed [CW-1:0] ri [3][3];
  logic signed [CW-1:0] rj [3][3];
  logic signed [CW-1:0] ti [3];
  logic signed [CW-1:0] tj [3];

  for (genvar r = 0; r < 3; r++) begin : g_unpack
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign ri[r][c] = cfg_q[r][CW*c +: CW];
      assign rj[r][c] = cfg_q[3+r][CW*c +: CW];
    end
    assign ti[r] = cfg_q[pplrj_pkg::REG_TRANS_I][CW*r +: CW];
    assign tj[r] = cfg_q[pplrj_pkg::REG_TRANS_J][CW*r +: CW];
  end

  // --------------------------------------------------------------------------
  // Flow control
  // --------------------------------------------------------------------------
  logic va_q, vb_q, vc_q, vd_q;
  logic buf_vld_q;
  logic [IXW-1:0] idx_q;
  logic buf_kind_q;
  logic out_take, out_last, load, en;

  assign out_take = buf_vld_q && res_o.ready;
  assign load     = vd_q && (!buf_vld_q || (out_take && out_last));
  assign en       = !vd_q || load;
  assign pt_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      va_q <= pt_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: rotate point, matched point and direction
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] p_in [3];
  logic signed [PW-1:0] q_in [3];
  logic signed [DW-1:0] d_in [3];

  assign p_in[0] = pt_i.src_x;
  assign p_in[1] = pt_i.src_y;
  assign p_in[2] = pt_i.src_z;
  assign q_in[0] = pt_i.dst_x;
  assign q_in[1] = pt_i.dst_y;
  assign q_in[2] = pt_i.dst_z;
  assign d_in[0] = pt_i.dir_x;
  assign d_in[1] = pt_i.dir_y;
  assign d_in[2] = pt_i.dir_z;

  logic signed [SW-1:0] wp_s [3];
  logic signed [SW-1:0] wq_s [3];
  logic signed [SW-1:0] wd_s [3];

  for (genvar r = 0; r < 3; r++) begin : g_sa
    assign wp_s[r] = ri[r][0] * p_in[0] + ri[r][1] * p_in[1] + ri[r][2] * p_in[2];
    assign wq_s[r] = rj[r][0] * q_in[0] + rj[r][1] * q_in[1] + rj[r][2] * q_in[2];
    assign wd_s[r] = ri[r][0] * d_in[0] + ri[r][1] * d_in[1] + ri[r][2] * d_in[2];
  end

  logic                  kind_a_q;
  logic signed [PW-1:0]  p_a_q [3];
  logic signed [PW-1:0]  q_a_q [3];
  logic signed [DW-1:0]  d_a_q [3];
  logic signed [WPW-1:0] wp_a_q [3];
  logic signed [WPW-1:0] wq_a_q [3];
  logic signed [WDW-1:0] wd_a_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_a_q <= pt_i.kind;
      for (int r = 0; r < 3; r++) begin
        p_a_q[r]  <= p_in[r];
        q_a_q[r]  <= q_in[r];
        d_a_q[r]  <= d_in[r];
        wp_a_q[r] <= WPW'(pplrj_pkg::rnd19(wp_s[r]));
        wq_a_q[r] <= WPW'(pplrj_pkg::rnd19(wq_s[r]));
        wd_a_q[r] <= WDW'(pplrj_pkg::rnd19(wd_s[r]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: world-frame difference
  // --------------------------------------------------------------------------
  logic                  kind_b_q;
  logic signed [PW-1:0]  p_b_q [3];
  logic signed [PW-1:0]  q_b_q [3];
  logic signed [DW-1:0]  d_b_q [3];
  logic signed [WDW-1:0] wd_b_q [3];
  logic signed [VW-1:0]  v_b_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_b_q <= kind_a_q;
      for (int r = 0; r < 3; r++) begin
        p_b_q[r]  <= p_a_q[r];
        q_b_q[r]  <= q_a_q[r];
        d_b_q[r]  <= d_a_q[r];
        wd_b_q[r] <= wd_a_q[r];
        v_b_q[r]  <= VW'(wq_a_q[r] + tj[r] * 4'sd4 - wp_a_q[r] - ti[r] * 4'sd4);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: residual sums and rotated normal/skew products
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] dot_s;
  logic signed [SW-1:0] crs_s  [3];
  logic signed [SW-1:0] rtn_s  [3];
  logic signed [SW-1:0] rtv_s  [3];
  logic signed [SW-1:0] rtnj_s [3];
  logic signed [SW-1:0] m1_s [3][3];
  logic signed [SW-1:0] m2_s [3][3];
  logic signed [SW-1:0] dv_s [3][3];

  assign dot_s = wd_b_q[0] * v_b_q[0] + wd_b_q[1] * v_b_q[1] + wd_b_q[2] * v_b_q[2];

  for (genvar r = 0; r < 3; r++) begin : g_sc
    localparam int R1 = (r + 1) % 3;
    localparam int R2 = (r + 2) % 3;
    assign crs_s[r]  = v_b_q[R1] * wd_b_q[R2] - v_b_q[R2] * wd_b_q[R1];
    assign rtn_s[r]  = ri[0][r] * wd_b_q[0] + ri[1][r] * wd_b_q[1] + ri[2][r] * wd_b_q[2];
    assign rtv_s[r]  = ri[0][r] * v_b_q[0] + ri[1][r] * v_b_q[1] + ri[2][r] * v_b_q[2];
    assign rtnj_s[r] = rj[0][r] * wd_b_q[0] + rj[1][r] * wd_b_q[1] + rj[2][r] * wd_b_q[2];
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign m1_s[r][c] = wd_b_q[R1] * ri[R2][c] - wd_b_q[R2] * ri[R1][c];
      assign m2_s[r][c] = wd_b_q[R1] * rj[R2][c] - wd_b_q[R2] * rj[R1][c];
      assign dv_s[r][c] = v_b_q[R1] * ri[R2][c] - v_b_q[R2] * ri[R1][c];
    end
  end

  logic                  kind_c_q;
  logic signed [PW-1:0]  p_c_q [3];
  logic signed [PW-1:0]  q_c_q [3];
  logic signed [DW-1:0]  d_c_q [3];
  logic signed [SW-1:0]  res_c_q [3];
  logic signed [MW-1:0]  rtn_c_q [3];
  logic signed [MVW-1:0] rtv_c_q [3];
  logic signed [MW-1:0]  rtnj_c_q [3];
  logic signed [MW-1:0]  m1_c_q [3][3];
  logic signed [MW-1:0]  m2_c_q [3][3];
  logic signed [MVW-1:0] dv_c_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_c_q <= kind_b_q;
      for (int r = 0; r < 3; r++) begin
        p_c_q[r]    <= p_b_q[r];
        q_c_q[r]    <= q_b_q[r];
        d_c_q[r]    <= d_b_q[r];
        res_c_q[r]  <= crs_s[r];
        rtn_c_q[r]  <= MW'(pplrj_pkg::rnd19(rtn_s[r]));
        rtv_c_q[r]  <= MVW'(pplrj_pkg::rnd19(rtv_s[r]));
        rtnj_c_q[r] <= MW'(pplrj_pkg::rnd19(rtnj_s[r]));
        for (int c = 0; c < 3; c++) begin
          m1_c_q[r][c] <= MW'(pplrj_pkg::rnd19(m1_s[r][c]));
          m2_c_q[r][c] <= MW'(pplrj_pkg::rnd19(m2_s[r][c]));
          dv_c_q[r][c] <= MVW'(pplrj_pkg::rnd19(dv_s[r][c]));
        end
      end
      // plane constraints carry their single residual in row 0
      if (kind_b_q == pplrj_pkg::KIND_PLANE) begin
        res_c_q[0] <= dot_s;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: Jacobian products
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] a_s  [3];
  logic signed [SW-1:0] b_s  [3];
  logic signed [SW-1:0] c2_s [3];
  logic signed [SW-1:0] t1_s [3][3];
  logic signed [SW-1:0] t2_s [3][3];
  logic signed [SW-1:0] t3_s [3][3];

  for (genvar c = 0; c < 3; c++) begin : g_sd
    localparam int C1 = (c + 1) % 3;
    localparam int C2 = (c + 2) % 3;
    assign a_s[c]  = rtn_c_q[C1] * p_c_q[C2] - rtn_c_q[C2] * p_c_q[C1];
    assign b_s[c]  = rtv_c_q[C1] * d_c_q[C2] - rtv_c_q[C2] * d_c_q[C1];
    assign c2_s[c] = rtnj_c_q[C1] * q_c_q[C2] - rtnj_c_q[C2] * q_c_q[C1];
    for (genvar r = 0; r < 3; r++) begin : g_row
      assign t1_s[r][c] = m1_c_q[r][C1] * p_c_q[C2] - m1_c_q[r][C2] * p_c_q[C1];
      assign t2_s[r][c] = dv_c_q[r][C1] * d_c_q[C2] - dv_c_q[r][C2] * d_c_q[C1];
      assign t3_s[r][c] = m2_c_q[r][C1] * q_c_q[C2] - m2_c_q[r][C2] * q_c_q[C1];
    end
  end

  logic                 kind_d_q;
  logic signed [SW-1:0] res_d_q [3];
  logic signed [SW-1:0] ra_d_q [3][3];
  logic signed [SW-1:0] rb_d_q [3][3];
  logic signed [TW-1:0] ta_d_q [3][3];
  logic signed [TW-1:0] tb_d_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_d_q <= kind_c_q;
      for (int r = 0; r < 3; r++) begin
        res_d_q[r] <= res_c_q[r];
        for (int c = 0; c < 3; c++) begin
          ra_d_q[r][c] <= -t1_s[r][c] - t2_s[r][c];
          rb_d_q[r][c] <= t3_s[r][c];
          ta_d_q[r][c] <= TW'(m1_c_q[r][c]);
          tb_d_q[r][c] <= -TW'(m2_c_q[r][c]);
        end
      end
      if (kind_c_q == pplrj_pkg::KIND_PLANE) begin
        for (int c = 0; c < 3; c++) begin
          ra_d_q[0][c] <= a_s[c] - b_s[c];
          rb_d_q[0][c] <= -c2_s[c];
          ta_d_q[0][c] <= -TW'(rtn_c_q[c]);
          tb_d_q[0][c] <= TW'(rtnj_c_q[c]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer: round, saturate, then, while res_o.ready is high, drain one item per cycle
  // --------------------------------------------------------------------------
  logic signed [OW-1:0] buf_res_q [3];
  logic signed [OW-1:0] buf_rot_q [2][3][3];
  logic signed [OW-1:0] buf_trn_q [2][3][3];

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_kind_q <= kind_d_q;
      for (int r = 0; r < 3; r++) begin
        buf_res_q[r] <= pplrj_pkg::sat32(pplrj_pkg::rnd16(res_d_q[r]));
        for (int c = 0; c < 3; c++) begin
          buf_rot_q[0][r][c] <= pplrj_pkg::sat32(pplrj_pkg::rnd16(ra_d_q[r][c]));
          buf_rot_q[1][r][c] <= pplrj_pkg::sat32(pplrj_pkg::rnd16(rb_d_q[r][c]));
          buf_trn_q[0][r][c] <= pplrj_pkg::sat32(SW'(ta_d_q[r][c]));
          buf_trn_q[1][r][c] <= pplrj_pkg::sat32(SW'(tb_d_q[r][c]));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (load) begin
      buf_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (out_take) begin
      // advance within the constraint, drop the buffer after its last transaction
      buf_vld_q <= !out_last;
      idx_q     <= idx_q + 1'b1;
    end
  end

  logic [1:0] out_row;
  logic       out_sel;

  assign out_row  = idx_q[IXW-1:1];
  assign out_sel  = idx_q[0];
  assign out_last = (buf_kind_q == pplrj_pkg::KIND_EDGE) ? (idx_q == pplrj_pkg::LAST_EDGE)
                                                         : (idx_q == pplrj_pkg::LAST_PLANE);

  assign res_o.valid          = buf_vld_q;
  assign res_o.residual_value = buf_res_q[out_row];
  assign res_o.residual_row   = out_row;
  assign res_o.pose_sel       = out_sel;
  assign res_o.rot_x          = buf_rot_q[out_sel][out_row][0];
  assign res_o.rot_y          = buf_rot_q[out_sel][out_row][1];
  assign res_o.rot_z          = buf_rot_q[out_sel][out_row][2];
  assign res_o.trans_x        = buf_trn_q[out_sel][out_row][0];
  assign res_o.trans_y        = buf_trn_q[out_sel][out_row][1];
  assign res_o.trans_z        = buf_trn_q[out_sel][out_row][2];
  assign res_o.last           = out_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PPLRJ_ASSERT(a_ready_when_drained, !vd_q |-> pt_i.ready, "input stalled with empty tail stage")
  `PPLRJ_ASSERT(a_last_second_pose, res_o.valid && res_o.last |-> res_o.pose_sel, "last on first pose")
  `PPLRJ_ASSERT(a_burst_continues, out_take && !out_last |=> res_o.valid && (res_o.pose_sel != $past(res_o.pose_sel)), "constraint burst broken")

endmodule

`default_nettype wire
